[hw/rtl/ntdt_pkg.sv]
// Shared constants, item types and helpers for the note-off deadline table.
`timescale 1ns / 1ps

package ntdt_pkg;

    localparam int NOTE_COUNT    = 128;
    localparam int CHANNEL_COUNT = 17;
    localparam int MAX_EVENTS    = 64;
    localparam int SAMPLE_BITS   = 48;

    localparam int ANY_CHANNEL = CHANNEL_COUNT - 1;
    localparam int NOTE_BITS   = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
    localparam int CH_BITS     = $clog2(CHANNEL_COUNT);
    localparam int ADDR_BITS   = CH_BITS + NOTE_BITS;
    localparam int MEM_DEPTH   = CHANNEL_COUNT * (2 ** NOTE_BITS);
    localparam int WORD_BITS   = SAMPLE_BITS + 1;
    localparam int COUNT_BITS  = $clog2(MAX_EVENTS + 1);

    localparam int MASK_BITS          = 17;
    localparam int CHANNEL_FIELD_BITS = 5;
    localparam int NOTE_FIELD_BITS    = 7;
    localparam int TIME_BITS          = 48;
    localparam int TICK_BITS          = 16;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic FUNC_ARM    = 1'b0;
    localparam logic FUNC_PERIOD = 1'b1;

    // register index as seen on paddr[2]
    localparam logic REG_SERVED_MASK = 1'b0;

    typedef struct packed {
        logic                          func;
        logic [CHANNEL_FIELD_BITS-1:0] channel;
        logic [NOTE_FIELD_BITS-1:0]    note;
        logic [TIME_BITS-1:0]          deadline;
        logic [TIME_BITS-1:0]          period_start;
        logic [TIME_BITS-1:0]          period_end;
    } cmd_t;

    typedef struct packed {
        logic [CHANNEL_FIELD_BITS-1:0] out_channel;
        logic [NOTE_FIELD_BITS-1:0]    out_note;
        logic [TICK_BITS-1:0]          tick;
        logic                          last;
    } evt_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    function automatic logic served(input logic [MASK_BITS-1:0] mask,
                                    input logic [CH_BITS-1:0]   c);
        logic r;
        if (mask == '0)
        begin
            r = 1'b0;
        end
        else if (mask[ANY_CHANNEL])
        begin
            r = 1'b1;
        end
        else if (c == CH_BITS'(ANY_CHANNEL))
        begin
            r = 1'b1;
        end
        else
        begin
            r = mask[c];
        end
        return r;
    endfunction

endpackage

[hw/rtl/ntdt_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module ntdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/note_off_deadline_table_top.sv]
// Top level of the note-off deadline table: APB register, command and event channels.
`timescale 1ns / 1ps

// Note-off deadline table.
// cmd channel (valid/ready) carries arm items (func 0) and period items (func 1).
// evt channel (valid/ready) carries one note-off per item, last set on the final
// note-off of a period. APB register 0 holds the served channel mask.
// An arm item writes one word of the deadline RAM if its channel and note are in range.
// A period item passes through PREP, then SCAN issues one RAM read per table
// entry, up to 2176 reads (channel x note, ascending), stopping once 64
// note-offs are found, and FLUSH drains it; the scan rate is set by the single
// RAM read port and drops while the output side stalls. One note-off is held
// back until the next is found so that last can be marked, plus one output register.
// When evt_valid is high, evt_ready is low and a new due entry turns up behind
// a held one, the scan re-reads that entry until the output side frees up;
// nothing is lost or reordered. cmd_ready is low while a period is processed.
// Reset: a clearing pass writes every RAM word with cmd_ready low; APB writes
// are taken during it.

module note_off_deadline_table_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ntdt_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [ntdt_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [ntdt_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  ntdt_pkg::cmd_t                       cmd,
    output logic                                 evt_valid,
    input  logic                                 evt_ready,
    output ntdt_pkg::evt_t                       evt
);

    localparam int SB = ntdt_pkg::SAMPLE_BITS;
    localparam int AB = ntdt_pkg::ADDR_BITS;
    localparam int NB = ntdt_pkg::NOTE_BITS;
    localparam int CB = ntdt_pkg::CH_BITS;
    localparam int TB = ntdt_pkg::TICK_BITS;

    ntdt_pkg::state_t                    state_reg, state_next;
    logic [ntdt_pkg::MASK_BITS-1:0]      mask_reg, mask_next;
    logic [SB-1:0]                       start_reg, start_next;
    logic [SB-1:0]                       end_reg, end_next;
    logic [SB-1:0]                       span_reg, span_next;
    logic                                empty_reg, empty_next;
    logic [CB-1:0]                       ch_reg, ch_next;
    logic [NB-1:0]                       nt_reg, nt_next;
    logic                                issue_done_reg, issue_done_next;
    logic [ntdt_pkg::COUNT_BITS-1:0]     count_reg, count_next;
    logic                                rd_vld_reg, rd_vld_next;
    logic [AB-1:0]                       rd_addr_reg, rd_addr_next;
    logic [AB-1:0]                       clr_addr_reg, clr_addr_next;
    logic                                hold_vld_reg, hold_vld_next;
    logic [AB-1:0]                       hold_addr_reg, hold_addr_next;
    logic [SB-1:0]                       hold_diff_reg, hold_diff_next;
    logic                                hold_early_reg, hold_early_next;
    logic                                evt_vld_reg, evt_vld_next;
    ntdt_pkg::evt_t                      evt_reg, evt_next;

    logic                                mem_we;
    logic [AB-1:0]                       mem_waddr;
    logic [ntdt_pkg::WORD_BITS-1:0]      mem_wdata;
    logic [AB-1:0]                       mem_raddr;
    logic [ntdt_pkg::WORD_BITS-1:0]      mem_rdata;

    logic                                rd_armed;
    logic [SB-1:0]                       rd_dl;
    logic                                rd_served;
    logic                                hit;
    logic                                hit_take;
    logic                                stall;
    logic                                out_free;
    logic [TB-1:0]                       limit;
    logic [TB-1:0]                       hold_tick;
    ntdt_pkg::evt_t                      hold_evt;
    logic                                arm_ok;
    logic                                cfg_wr;

    // armed flag in the top bit, deadline below
    ntdt_ram #(
        .WIDTH (ntdt_pkg::WORD_BITS),
        .DEPTH (ntdt_pkg::MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ntdt_pkg::REG_SERVED_MASK)
                  ? ntdt_pkg::APB_DATA_BITS'(mask_reg) : '0;

    assign evt_valid = evt_vld_reg;
    assign evt       = evt_reg;

    assign rd_armed  = mem_rdata[ntdt_pkg::WORD_BITS-1];
    assign rd_dl     = mem_rdata[SB-1:0];
    assign rd_served = ntdt_pkg::served(mask_reg, rd_addr_reg[AB-1:NB]);
    assign out_free  = !evt_vld_reg || evt_ready;

    assign hit = (state_reg == ntdt_pkg::ST_SCAN) && rd_vld_reg && rd_armed && rd_served
              && (rd_dl < end_reg) && (count_reg < ntdt_pkg::COUNT_BITS'(ntdt_pkg::MAX_EVENTS));
    assign hit_take = hit && (!hold_vld_reg || out_free);
    assign stall    = hit && !hit_take;

    // min(period length - 1, 65535)
    assign limit = (span_reg[SB-1:TB] != '0) ? ntdt_pkg::TICK_MAX
                                             : span_reg[TB-1:0] - TB'(1);

    always_comb
    begin
        if (hold_early_reg || empty_reg)
        begin
            hold_tick = '0;
        end
        else if ((hold_diff_reg[SB-1:TB] != '0) || (hold_diff_reg[TB-1:0] > limit))
        begin
            hold_tick = limit;
        end
        else
        begin
            hold_tick = hold_diff_reg[TB-1:0];
        end
    end

    always_comb
    begin
        hold_evt.out_channel = ntdt_pkg::CHANNEL_FIELD_BITS'(hold_addr_reg[AB-1:NB]);
        hold_evt.out_note    = ntdt_pkg::NOTE_FIELD_BITS'(hold_addr_reg[NB-1:0]);
        hold_evt.tick        = hold_tick;
        hold_evt.last        = 1'b0;
    end

    assign arm_ok =
        ({1'b0, cmd.channel} < (ntdt_pkg::CHANNEL_FIELD_BITS + 1)'(ntdt_pkg::CHANNEL_COUNT))
     && ({1'b0, cmd.note} < (ntdt_pkg::NOTE_FIELD_BITS + 1)'(ntdt_pkg::NOTE_COUNT));

    always_comb
    begin
        state_next      = state_reg;
        mask_next       = mask_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        span_next       = span_reg;
        empty_next      = empty_reg;
        ch_next         = ch_reg;
        nt_next         = nt_reg;
        issue_done_next = issue_done_reg;
        count_next      = count_reg;
        rd_vld_next     = 1'b0;
        rd_addr_next    = rd_addr_reg;
        clr_addr_next   = clr_addr_reg;
        hold_vld_next   = hold_vld_reg;
        hold_addr_next  = hold_addr_reg;
        hold_diff_next  = hold_diff_reg;
        hold_early_next = hold_early_reg;
        evt_vld_next    = evt_vld_reg && !evt_ready;
        evt_next        = evt_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_addr_reg;
        mem_wdata       = {1'b0, rd_dl};
        mem_raddr       = {ch_reg, nt_reg};
        cmd_ready       = 1'b0;

        if (cfg_wr && (paddr[2] == ntdt_pkg::REG_SERVED_MASK))
        begin
            mask_next = pwdata[ntdt_pkg::MASK_BITS-1:0];
        end

        case (state_reg)
            ntdt_pkg::ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + AB'(1);
                if (clr_addr_reg == AB'(ntdt_pkg::MEM_DEPTH - 1))
                begin
                    state_next = ntdt_pkg::ST_IDLE;
                end
            end

            ntdt_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd.func == ntdt_pkg::FUNC_ARM)
                    begin
                        mem_we    = arm_ok;
                        mem_waddr = {cmd.channel[CB-1:0], cmd.note[NB-1:0]};
                        mem_wdata = {1'b1, SB'(cmd.deadline)};
                    end
                    else
                    begin
                        start_next = SB'(cmd.period_start);
                        end_next   = SB'(cmd.period_end);
                        state_next = ntdt_pkg::ST_PREP;
                    end
                end
            end

            ntdt_pkg::ST_PREP:
            begin
                span_next       = end_reg - start_reg;
                empty_next      = (end_reg <= start_reg);
                ch_next         = '0;
                nt_next         = '0;
                issue_done_next = 1'b0;
                count_next      = '0;
                state_next      = ntdt_pkg::ST_SCAN;
            end

            ntdt_pkg::ST_SCAN:
            begin
                if (hit_take)
                begin
                    // disarm the entry, keep this note-off back until the next one shows
                    mem_we          = 1'b1;
                    count_next      = count_reg + ntdt_pkg::COUNT_BITS'(1);
                    hold_vld_next   = 1'b1;
                    hold_addr_next  = rd_addr_reg;
                    hold_diff_next  = rd_dl - start_reg;
                    hold_early_next = (rd_dl <= start_reg);
                    if (hold_vld_reg)
                    begin
                        evt_vld_next = 1'b1;
                        evt_next     = hold_evt;
                    end
                end

                if (stall)
                begin
                    // output side full: read the same entry again
                    mem_raddr    = rd_addr_reg;
                    rd_vld_next  = 1'b1;
                end
                else if (!issue_done_reg
                         && (count_reg != ntdt_pkg::COUNT_BITS'(ntdt_pkg::MAX_EVENTS)))
                begin
                    rd_vld_next  = 1'b1;
                    rd_addr_next = {ch_reg, nt_reg};
                    if (nt_reg == NB'(ntdt_pkg::NOTE_COUNT - 1))
                    begin
                        nt_next = '0;
                        if (ch_reg == CB'(ntdt_pkg::CHANNEL_COUNT - 1))
                        begin
                            issue_done_next = 1'b1;
                        end
                        else
                        begin
                            ch_next = ch_reg + CB'(1);
                        end
                    end
                    else
                    begin
                        nt_next = nt_reg + NB'(1);
                    end
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ntdt_pkg::ST_FLUSH;
                end
            end

            ntdt_pkg::ST_FLUSH:
            begin
                if (!hold_vld_reg)
                begin
                    state_next = ntdt_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    evt_vld_next  = 1'b1;
                    evt_next      = hold_evt;
                    evt_next.last = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next    = ntdt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ntdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ntdt_pkg::ST_CLEAR;
            mask_reg       <= '0;
            ch_reg         <= '0;
            nt_reg         <= '0;
            issue_done_reg <= 1'b0;
            count_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            clr_addr_reg   <= '0;
            hold_vld_reg   <= 1'b0;
            evt_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mask_reg       <= mask_next;
            ch_reg         <= ch_next;
            nt_reg         <= nt_next;
            issue_done_reg <= issue_done_next;
            count_reg      <= count_next;
            rd_vld_reg     <= rd_vld_next;
            clr_addr_reg   <= clr_addr_next;
            hold_vld_reg   <= hold_vld_next;
            evt_vld_reg    <= evt_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        end_reg        <= end_next;
        span_reg       <= span_next;
        empty_reg      <= empty_next;
        rd_addr_reg    <= rd_addr_next;
        hold_addr_reg  <= hold_addr_next;
        hold_diff_reg  <= hold_diff_next;
        hold_early_reg <= hold_early_next;
        evt_reg        <= evt_next;
    end

endmodule

[hw/rtl/ntdt_checker.sv]
// Port-level checks for the note-off deadline table, bound to the top level.
`timescale 1ns / 1ps

module ntdt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input ntdt_pkg::cmd_t cmd,
    input logic           evt_valid,
    input logic           evt_ready,
    input ntdt_pkg::evt_t evt
);

    // a stalled note-off holds
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt))
        else $error("note-off item changed while stalled");

    // a period item blocks the command channel while it is scanned
    a_period_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.func == ntdt_pkg::FUNC_PERIOD) |=> !cmd_ready)
        else $error("command taken during period scan");

    // an arm item finishes in the cycle it is taken
    a_arm_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.func == ntdt_pkg::FUNC_ARM) |=> cmd_ready)
        else $error("arm item did not complete in one cycle");

    a_evt_channel: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (evt.out_channel
                       < ntdt_pkg::CHANNEL_FIELD_BITS'(ntdt_pkg::CHANNEL_COUNT)))
        else $error("note-off channel out of range");

endmodule

bind note_off_deadline_table_top ntdt_checker u_ntdt_checker (.*);
